### hdl/gls_pkg.sv
`default_nettype none
package gls_pkg;

  localparam int MAX_DIM     = 16;
  localparam int DATA_W      = 32;
  localparam int FRAC_W      = 16;
  localparam int STORE_DEPTH = MAX_DIM * (MAX_DIM + 1);
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int DIM_W       = 5;
  localparam int IDX_W       = 4;
  localparam int THR_W       = 31;
  localparam int CNT_W       = 9;
  localparam int DIVD_W      = DATA_W + FRAC_W;
  localparam int ACC_W       = 56;

  localparam logic REG_SYSTEM_SIZE     = 1'b0;
  localparam logic REG_PIVOT_THRESHOLD = 1'b1;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic [IDX_W-1:0]  idx;
    logic              sing;
    logic              last;
  } result_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > 64'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[DATA_W-1:0];
    return r;
  endfunction

  // product / 2^16, truncated toward zero
  function automatic logic signed [47:0] scale_frac(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p[63] ? p + 64'sd65535 : p;
    return t[63:16];
  endfunction

  function automatic logic [32:0] mag33(input logic signed [DATA_W-1:0] v);
    logic [32:0] e;
    e = {v[DATA_W-1], v};
    return v[DATA_W-1] ? 33'(-e) : e;
  endfunction

  function automatic logic [ADDR_W-1:0] entry_addr(input logic [IDX_W-1:0] ph,
                                                  input logic [DIM_W-1:0] n,
                                                  input logic [DIM_W-1:0] c);
    logic [ADDR_W-1:0] w;
    w = ADDR_W'(ph) * (ADDR_W'(n) + ADDR_W'(1));
    return w + ADDR_W'(c);
  endfunction

  function automatic logic [DIM_W-1:0] active_size(input logic [DIM_W-1:0] s);
    logic [DIM_W-1:0] r;
    if (s == '0) r = DIM_W'(1);
    else if (s > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
    else r = s;
    return r;
  endfunction

endpackage
`default_nettype wire

### hdl/gaussian_linear_solve.sv
// Solve: the transfer that completes a load of n*(n+1) entries launches the solve, which
//   runs a pivot search over the rows, one serial divide per eliminated row and per
//   unknown, and a read-modify-write loop over the entries.
// Throughput: one entry per cycle while loading; no entry is taken during the solve or
//   while results wait. Results leave at one per cycle once the consumer is ready.
// Reset (rst_n low, synchronous): load count cleared, system_size 16, threshold 1.
`default_nettype none
module gaussian_linear_solve (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] entry_value
  input  wire logic [0:0]  in_tuser,   // [0] first_of_system
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // [31:0] solution_value, [35:32] unknown_index, zero pad
  output logic [0:0]       out_tuser,  // [0] singular
  output logic             out_tlast,  // last_result
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [30:0] cfg_wdata
);
  // Configuration registers
  logic [gls_pkg::DIM_W-1:0] size_r;
  logic [gls_pkg::THR_W-1:0] thr_r;

  // Loader
  logic [gls_pkg::CNT_W-1:0] load_cnt_r;
  logic                      start_r;
  logic [gls_pkg::DIM_W-1:0] n_act, n_start_r;
  logic [gls_pkg::CNT_W-1:0] total, cnt0, cnt1;
  logic                      in_xfer, busy;

  gls_pkg::mem_req_t solver_req, mem_req;
  logic [gls_pkg::DATA_W-1:0] mem_rdata;
  gls_pkg::result_t res;

  assign in_tready = !busy && !start_r;
  assign in_xfer   = in_tvalid && in_tready;

  assign n_act = gls_pkg::active_size(size_r);
  assign total = gls_pkg::CNT_W'(n_act) * (gls_pkg::CNT_W'(n_act) + gls_pkg::CNT_W'(1));
  assign cnt0  = in_tuser[0] ? '0 : load_cnt_r;
  // hold the count at its top so it never wraps
  assign cnt1  = (cnt0 < {gls_pkg::CNT_W{1'b1}}) ? cnt0 + gls_pkg::CNT_W'(1) : cnt0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r     <= gls_pkg::DIM_W'(gls_pkg::MAX_DIM);
      thr_r      <= gls_pkg::THR_W'(1);
      load_cnt_r <= '0;
      start_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index[0])
          gls_pkg::REG_SYSTEM_SIZE:     size_r <= cfg_wdata[gls_pkg::DIM_W-1:0];
          gls_pkg::REG_PIVOT_THRESHOLD: thr_r  <= cfg_wdata;
          default: ;
        endcase
      end
      start_r <= 1'b0;
      if (in_xfer) begin
        // the transfer that fills the system launches the solve
        if (cnt1 >= total) begin
          load_cnt_r <= '0;
          start_r    <= 1'b1;
          n_start_r  <= n_act;
        end else begin
          load_cnt_r <= cnt1;
        end
      end
    end
  end

  // Loader owns the write port while the solver sits idle
  always_comb begin
    mem_req = solver_req;
    if (in_xfer) begin
      mem_req.we    = (cnt0 < gls_pkg::CNT_W'(gls_pkg::STORE_DEPTH));
      mem_req.waddr = cnt0[gls_pkg::ADDR_W-1:0];
      mem_req.wdata = in_tdata;
    end
  end

  gls_store u_store (.clk(clk), .req(mem_req), .rdata(mem_rdata));

  gls_solver u_solver (
    .clk(clk), .rst_n(rst_n), .start(start_r), .n_in(n_start_r), .thr(thr_r),
    .busy(busy), .mem_req(solver_req), .mem_rdata(mem_rdata),
    .res_valid(out_tvalid), .res_ready(out_tready), .res(res)
  );

  assign out_tdata = {4'b0, res.idx, res.value};
  assign out_tuser = res.sing;
  assign out_tlast = res.last;
endmodule
`default_nettype wire

### hdl/gls_store.sv
`default_nettype none
module gls_store (
  input  wire logic                      clk,
  input  wire gls_pkg::mem_req_t         req,
  output logic [gls_pkg::DATA_W-1:0]     rdata
);
  logic [gls_pkg::DATA_W-1:0] mem [gls_pkg::STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end
endmodule
`default_nettype wire

### hdl/gls_div.sv
`default_nettype none
module gls_div (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  input  wire logic signed [gls_pkg::DIVD_W-1:0] dividend,
  input  wire logic signed [gls_pkg::DATA_W-1:0] divisor,
  output logic                                   done,
  output logic signed [gls_pkg::DATA_W-1:0]      quot
);
  localparam int QW = gls_pkg::DIVD_W;

  logic          run_r;
  logic          done_r;
  logic [5:0]    cnt_r;
  logic [32:0]   rem_r;
  logic [QW-1:0] quo_r;
  logic [31:0]   dmag_r;
  logic          neg_r;
  logic [32:0]   rem_s;
  logic          qbit;
  logic signed [63:0] qsig;

  assign rem_s = {rem_r[31:0], quo_r[QW-1]};
  assign qbit  = (rem_s >= {1'b0, dmag_r});
  assign qsig  = neg_r ? -$signed({16'b0, quo_r}) : $signed({16'b0, quo_r});
  assign quot  = gls_pkg::sat32(qsig);
  assign done  = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r  <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        quo_r  <= dividend[QW-1] ? QW'(-dividend) : QW'(dividend);
        dmag_r <= divisor[31] ? 32'(-divisor) : 32'(divisor);
        neg_r  <= dividend[QW-1] ^ divisor[31];
      end else if (run_r) begin
        rem_r <= qbit ? rem_s - {1'b0, dmag_r} : rem_s;
        quo_r <= {quo_r[QW-2:0], qbit};
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'(QW - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

### hdl/gls_solver.sv
`default_nettype none
module gls_solver (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [gls_pkg::DIM_W-1:0]     n_in,
  input  wire logic [gls_pkg::THR_W-1:0]     thr,
  output logic                               busy,
  output gls_pkg::mem_req_t                  mem_req,
  input  wire logic [gls_pkg::DATA_W-1:0]    mem_rdata,
  output logic                               res_valid,
  input  wire logic                          res_ready,
  output gls_pkg::result_t                   res
);
  localparam int DW = gls_pkg::DATA_W;
  localparam int NW = gls_pkg::DIM_W;
  localparam int IW = gls_pkg::IDX_W;

  typedef enum logic [4:0] {
    S_IDLE, S_PS_INIT, S_PS_A, S_PS_B, S_PCHK, S_ROW, S_ROW_D, S_DIVW,
    S_UPD_A, S_UPD_B, S_UPD_C, S_BS_ROW, S_BS_RHS, S_BS_A, S_BS_B, S_BS_C,
    S_BS_DIAG, S_BS_DD, S_BS_DW, S_OUT, S_SING
  } state_t;

  state_t state_r;
  logic [NW-1:0] n_r, k_r, i_r, j_r;
  logic [IW-1:0] r_r, o_r;
  logic [IW-1:0] perm_r [gls_pkg::MAX_DIM];
  logic signed [DW-1:0] x_r [gls_pkg::MAX_DIM];
  logic [32:0] best_mag_r;
  logic [IW-1:0] best_l_r, best_ph_r, ph_r, prk_r, pri_r;
  logic signed [DW-1:0] piv_r, mi_r;
  logic signed [63:0] prod_r;
  logic signed [gls_pkg::ACC_W-1:0] acc_r;

  logic [IW-1:0] perm_idx, perm_rd, x_idx;
  logic signed [DW-1:0] x_rd, rd;
  logic [32:0] rd_mag;
  logic signed [63:0] mul;
  logic signed [63:0] upd;
  logic div_start, div_done;
  logic signed [gls_pkg::DIVD_W-1:0] div_dvd;
  logic signed [DW-1:0] div_dvs, div_q;

  assign rd     = $signed(mem_rdata);
  assign rd_mag = gls_pkg::mag33(rd);

  always_comb begin
    case (state_r)
      S_PCHK:   perm_idx = k_r[IW-1:0];
      S_BS_ROW: perm_idx = r_r;
      default:  perm_idx = i_r[IW-1:0];
    endcase
  end
  assign perm_rd = perm_r[perm_idx];
  assign x_idx   = (state_r == S_OUT) ? o_r : j_r[IW-1:0];
  assign x_rd    = x_r[x_idx];

  always_comb begin
    mul = $signed({{32{rd[DW-1]}}, rd}) * ((state_r == S_BS_B)
          ? $signed({{32{x_rd[DW-1]}}, x_rd}) : $signed({{32{mi_r[DW-1]}}, mi_r}));
  end
  assign upd = 64'(rd) - 64'(gls_pkg::scale_frac(prod_r));

  always_comb begin
    mem_req.we    = (state_r == S_UPD_C);
    mem_req.waddr = gls_pkg::entry_addr(pri_r, n_r, j_r);
    mem_req.wdata = gls_pkg::sat32(upd);
    case (state_r)
      S_PS_A:    mem_req.raddr = gls_pkg::entry_addr(perm_rd, n_r, k_r);
      S_ROW:     mem_req.raddr = gls_pkg::entry_addr(perm_rd, n_r, k_r);
      S_UPD_A:   mem_req.raddr = gls_pkg::entry_addr(prk_r, n_r, j_r);
      S_UPD_B:   mem_req.raddr = gls_pkg::entry_addr(pri_r, n_r, j_r);
      S_BS_ROW:  mem_req.raddr = gls_pkg::entry_addr(perm_rd, n_r, n_r);
      S_BS_A:    mem_req.raddr = gls_pkg::entry_addr(pri_r, n_r, j_r);
      S_BS_DIAG: mem_req.raddr = gls_pkg::entry_addr(pri_r, n_r, NW'(r_r));
      default:   mem_req.raddr = '0;
    endcase
  end

  assign div_start = (state_r == S_ROW_D) || (state_r == S_BS_DD);
  always_comb begin
    if (state_r == S_BS_DD) begin
      div_dvd = {gls_pkg::sat32(64'(acc_r)), 16'b0};
      div_dvs = rd;
    end else begin
      div_dvd = {rd, 16'b0};
      div_dvs = piv_r;
    end
  end

  gls_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dvd),
    .divisor(div_dvs), .done(div_done), .quot(div_q)
  );

  assign busy      = (state_r != S_IDLE);
  assign res_valid = (state_r == S_OUT) || (state_r == S_SING);
  always_comb begin
    if (state_r == S_SING) begin
      res.value = '0;
      res.idx   = k_r[IW-1:0];
      res.sing  = 1'b1;
      res.last  = 1'b1;
    end else begin
      res.value = x_rd;
      res.idx   = o_r;
      res.sing  = 1'b0;
      res.last  = (NW'(o_r) + NW'(1) == n_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: if (start) begin
          n_r <= n_in;
          k_r <= '0;
          for (int q = 0; q < gls_pkg::MAX_DIM; q++) perm_r[q] <= IW'(q);
          state_r <= S_PS_INIT;
        end
        S_PS_INIT: begin
          i_r <= k_r;
          best_mag_r <= '0;
          state_r <= S_PS_A;
        end
        S_PS_A: begin
          ph_r <= perm_rd;
          state_r <= S_PS_B;
        end
        S_PS_B: begin
          if (i_r == k_r || rd_mag > best_mag_r) begin
            best_mag_r <= rd_mag;
            best_l_r   <= i_r[IW-1:0];
            best_ph_r  <= ph_r;
            piv_r      <= rd;
          end
          if (i_r + NW'(1) == n_r) state_r <= S_PCHK;
          else begin
            i_r <= i_r + NW'(1);
            state_r <= S_PS_A;
          end
        end
        S_PCHK: begin
          if (best_mag_r == '0 || best_mag_r < {2'b0, thr}) begin
            state_r <= S_SING;
          end else begin
            if (best_l_r != k_r[IW-1:0]) perm_r[best_l_r] <= perm_rd;
            perm_r[k_r[IW-1:0]]  <= best_ph_r;
            prk_r <= best_ph_r;
            if (k_r + NW'(1) == n_r) begin
              r_r <= IW'(n_r - NW'(1));
              state_r <= S_BS_ROW;
            end else begin
              i_r <= k_r + NW'(1);
              state_r <= S_ROW;
            end
          end
        end
        S_ROW: begin
          pri_r <= perm_rd;
          state_r <= S_ROW_D;
        end
        S_ROW_D: state_r <= S_DIVW;
        S_DIVW: if (div_done) begin
          mi_r <= div_q;
          j_r  <= k_r + NW'(1);
          state_r <= S_UPD_A;
        end
        S_UPD_A: state_r <= S_UPD_B;
        S_UPD_B: begin
          prod_r <= mul;
          state_r <= S_UPD_C;
        end
        S_UPD_C: begin
          if (j_r == n_r) begin
            if (i_r + NW'(1) == n_r) begin
              k_r <= k_r + NW'(1);
              state_r <= S_PS_INIT;
            end else begin
              i_r <= i_r + NW'(1);
              state_r <= S_ROW;
            end
          end else begin
            j_r <= j_r + NW'(1);
            state_r <= S_UPD_A;
          end
        end
        S_BS_ROW: begin
          pri_r <= perm_rd;
          state_r <= S_BS_RHS;
        end
        S_BS_RHS: begin
          acc_r <= gls_pkg::ACC_W'(rd);
          j_r   <= NW'(r_r) + NW'(1);
          state_r <= (NW'(r_r) + NW'(1) == n_r) ? S_BS_DIAG : S_BS_A;
        end
        S_BS_A: state_r <= S_BS_B;
        S_BS_B: begin
          prod_r <= mul;
          state_r <= S_BS_C;
        end
        S_BS_C: begin
          acc_r <= acc_r - gls_pkg::ACC_W'(gls_pkg::scale_frac(prod_r));
          if (j_r + NW'(1) == n_r) state_r <= S_BS_DIAG;
          else begin
            j_r <= j_r + NW'(1);
            state_r <= S_BS_A;
          end
        end
        S_BS_DIAG: state_r <= S_BS_DD;
        S_BS_DD:   state_r <= S_BS_DW;
        S_BS_DW: if (div_done) begin
          x_r[r_r] <= div_q;
          if (r_r == '0) begin
            o_r <= '0;
            state_r <= S_OUT;
          end else begin
            r_r <= r_r - IW'(1);
            state_r <= S_BS_ROW;
          end
        end
        S_OUT: if (res_ready) begin
          if (NW'(o_r) + NW'(1) == n_r) state_r <= S_IDLE;
          else o_r <= o_r + IW'(1);
        end
        S_SING: if (res_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### hdl/gls_checker.sv
`default_nettype none
module gls_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata,
  input wire logic [0:0]  out_tuser,
  input wire logic        out_tlast
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("entry taken while results pending");

  a_sing_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast && out_tdata[31:0] == 32'd0)
    else $error("malformed singular result");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> !out_tvalid)
    else $error("result after last");
endmodule

bind gaussian_linear_solve gls_checker u_gls_checker (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tuser(out_tuser), .out_tlast(out_tlast)
);
`default_nettype wire
